>>> hw/rtl/matrix_vector_multiply_assert.svh
// ----------------------------------------------------------------------------
// Matrix-vector multiply assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MATRIX_VECTOR_MULTIPLY_ASSERT_SVH
`define MATRIX_VECTOR_MULTIPLY_ASSERT_SVH

// Same-cycle implication.
`define MVM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mvm assertion failed");

// Next-cycle implication.
`define MVM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mvm assertion failed");

`endif

>>> hw/rtl/mvm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvm_pkg
// Types and constants shared by the matrix-vector multiply block.
// ----------------------------------------------------------------------------
package mvm_pkg;

  localparam int MAX_ROWS  = 64;
  localparam int MAX_COLS  = 64;
  localparam int VEC_DEPTH = 64;

  localparam int IDX_W     = 6;
  localparam int VAL_W     = 16;
  localparam int PROD_W    = 2 * VAL_W;
  localparam int RES_W     = 48;
  localparam int DIM_W     = 7;
  localparam int CFG_IDX_W = 2;

  // effective dimension limits
  localparam int ROW_LIM = (MAX_ROWS < VEC_DEPTH) ? MAX_ROWS : VEC_DEPTH;
  localparam int COL_LIM = (MAX_COLS < VEC_DEPTH) ? MAX_COLS : VEC_DEPTH;

  localparam int WDEPTH  = MAX_ROWS * MAX_COLS;
  localparam int WADDR_W = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int VADDR_W = $clog2(VEC_DEPTH);

  localparam logic CMD_MATRIX = 1'b0;
  localparam logic CMD_VECTOR = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  // control that travels with one product term down the MAC pipe
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             term_last;
    logic             zero;
    logic             out_last;
    logic [IDX_W-1:0] idx;
  } term_ctrl_t;

endpackage

>>> hw/rtl/mvm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvm_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mvm_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/mvm_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvm_mac
// Shared multiply-accumulate: registered product, then 48-bit accumulate,
// emitting one registered result at the last term of each dot product.
// ----------------------------------------------------------------------------
module mvm_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mvm_pkg::term_ctrl_t               term_in,
  input  logic signed [mvm_pkg::VAL_W-1:0]  w_in,
  input  logic signed [mvm_pkg::VAL_W-1:0]  v_in,
  output logic                              res_valid,
  output logic        [mvm_pkg::IDX_W-1:0]  res_index,
  output logic signed [mvm_pkg::RES_W-1:0]  res_value,
  output logic                              res_last
);

  mvm_pkg::term_ctrl_t                     term_r;
  logic signed [mvm_pkg::PROD_W-1:0]       prod_nxt;
  logic signed [mvm_pkg::PROD_W-1:0]       prod_r;
  logic signed [mvm_pkg::RES_W-1:0]        acc_r;
  logic signed [mvm_pkg::RES_W-1:0]        acc_nxt;
  logic signed [mvm_pkg::RES_W-1:0]        prod_ext;
  logic                                    res_valid_r;
  logic        [mvm_pkg::IDX_W-1:0]        res_index_r;
  logic signed [mvm_pkg::RES_W-1:0]        res_value_r;
  logic                                    res_last_r;

  // signed 16 x 16 product, sized on its own
  assign prod_nxt = w_in * v_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_r.valid <= 1'b0;
    end else begin
      term_r <= term_in;
    end
    prod_r <= term_in.zero ? '0 : prod_nxt;
  end

  assign prod_ext = {{(mvm_pkg::RES_W - mvm_pkg::PROD_W){prod_r[mvm_pkg::PROD_W-1]}}, prod_r};
  assign acc_nxt  = (term_r.first ? '0 : acc_r) + prod_ext;

  always_ff @(posedge clk) begin
    if (term_r.valid) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= term_r.valid && term_r.term_last;
    end
    if (term_r.valid && term_r.term_last) begin
      res_index_r <= term_r.idx;
      res_value_r <= acc_nxt;
      res_last_r  <= term_r.out_last;
    end
  end

  assign res_valid = res_valid_r;
  assign res_index = res_index_r;
  assign res_value = res_value_r;
  assign res_last  = res_last_r;

endmodule

>>> hw/rtl/matrix_vector_multiply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_vector_multiply
// Weight matrix and vector buffer in RAM, one shared MAC under a sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a transaction is taken when start is high and busy is low.
//   in_command 0 writes one weight; 1 writes one vector element, and with
//   in_is_last set it also starts the product if n_out is nonzero.
//   Only a vector write with in_is_last that starts a product raises busy.
//   A product walks n_out * max(n_sum, 1) terms through one multiply-
//   accumulate, one term per cycle, from the weight and vector RAM reads;
//   busy stays high until the pipe has drained.
//   n_out is rows (normal) or cols (transpose); n_sum is the other one.
//   Each result strobes once its last term has passed s1_r and the MAC
//   registers; results come in index order, out_result_last on the final one.
//   Each result is on out_* for exactly one cycle with out_valid high;
//   the receiver cannot stall.
//   Config: cfg_ready is always high; write only while the block is idle.
//   Reset (rst_n low, synchronous) sets rows 64, cols 64, normal mode and
//   returns the sequencer to idle; RAM contents are undefined until written.
// ----------------------------------------------------------------------------
module matrix_vector_multiply (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // command channel
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_command,
  input  logic        [mvm_pkg::IDX_W-1:0]      in_row_index,
  input  logic        [mvm_pkg::IDX_W-1:0]      in_col_index,
  input  logic signed [mvm_pkg::VAL_W-1:0]      in_matrix_value,
  input  logic        [mvm_pkg::IDX_W-1:0]      in_vector_index,
  input  logic signed [mvm_pkg::VAL_W-1:0]      in_vector_value,
  input  logic                                  in_is_last,
  // result channel
  output logic                                  out_valid,
  output logic        [mvm_pkg::IDX_W-1:0]      out_result_index,
  output logic signed [mvm_pkg::RES_W-1:0]      out_result_value,
  output logic                                  out_result_last,
  // configuration channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic        [mvm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [mvm_pkg::DIM_W-1:0]      cfg_data
);

  logic [mvm_pkg::DIM_W-1:0] rows_r;
  logic [mvm_pkg::DIM_W-1:0] cols_r;
  logic                      transpose_r;

  mvm_pkg::state_t           state_r, state_nxt;
  logic [mvm_pkg::IDX_W-1:0] k_r, k_nxt;
  logic [mvm_pkg::IDX_W-1:0] m_r, m_nxt;
  mvm_pkg::term_ctrl_t       issue;
  mvm_pkg::term_ctrl_t       s1_r;
  logic                      mac_busy_r;

  logic                      in_accept;
  logic                      run_start;
  logic                      cfg_write;
  logic [mvm_pkg::DIM_W-1:0] rows_eff;
  logic [mvm_pkg::DIM_W-1:0] cols_eff;
  logic [mvm_pkg::DIM_W-1:0] n_out;
  logic [mvm_pkg::DIM_W-1:0] n_sum;
  logic                      term_last;
  logic                      out_last;
  logic [mvm_pkg::IDX_W-1:0] rd_row;
  logic [mvm_pkg::IDX_W-1:0] rd_col;

  logic                        w_we;
  logic [mvm_pkg::WADDR_W-1:0] w_waddr;
  logic [mvm_pkg::WADDR_W-1:0] w_raddr;
  logic [mvm_pkg::VAL_W-1:0]   w_rdata;
  logic                        v_we;
  logic [mvm_pkg::VADDR_W-1:0] v_waddr;
  logic [mvm_pkg::VADDR_W-1:0] v_raddr;
  logic [mvm_pkg::VAL_W-1:0]   v_rdata;

  assign in_accept = start && !busy;
  assign busy      = (state_r != mvm_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign run_start = in_accept && (in_command == mvm_pkg::CMD_VECTOR) && in_is_last
                     && (n_out != '0);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r      <= mvm_pkg::DIM_W'(64);
      cols_r      <= mvm_pkg::DIM_W'(64);
      transpose_r <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        mvm_pkg::CFG_ROWS:      rows_r      <= cfg_data;
        mvm_pkg::CFG_COLS:      cols_r      <= cfg_data;
        mvm_pkg::CFG_TRANSPOSE: transpose_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign rows_eff = (int'(rows_r) > mvm_pkg::ROW_LIM) ?
                    mvm_pkg::DIM_W'(mvm_pkg::ROW_LIM) : rows_r;
  assign cols_eff = (int'(cols_r) > mvm_pkg::COL_LIM) ?
                    mvm_pkg::DIM_W'(mvm_pkg::COL_LIM) : cols_r;
  assign n_out    = transpose_r ? cols_eff : rows_eff;
  assign n_sum    = transpose_r ? rows_eff : cols_eff;

  // an empty sum still issues one zeroed term per output
  assign term_last = (n_sum == '0) || ({1'b0, m_r} + 1'b1 == n_sum);
  assign out_last  = ({1'b0, k_r} + 1'b1 == n_out);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mvm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    k_r <= k_nxt;
    m_r <= m_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    k_nxt           = k_r;
    m_nxt           = m_r;
    issue.valid     = 1'b0;
    issue.first     = (m_r == '0);
    issue.term_last = term_last;
    issue.zero      = (n_sum == '0);
    issue.out_last  = out_last;
    issue.idx       = k_r;
    case (state_r)
      mvm_pkg::ST_IDLE: begin
        k_nxt = '0;
        m_nxt = '0;
        if (run_start) begin
          state_nxt = mvm_pkg::ST_RUN;
        end
      end
      mvm_pkg::ST_RUN: begin
        issue.valid = 1'b1;
        if (term_last) begin
          m_nxt = '0;
          if (out_last) begin
            state_nxt = mvm_pkg::ST_DRAIN;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end else begin
          m_nxt = m_r + 1'b1;
        end
      end
      mvm_pkg::ST_DRAIN: begin
        if (!s1_r.valid && !mac_busy_r) begin
          state_nxt = mvm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mvm_pkg::ST_IDLE;
    endcase
  end

  // term control delayed to line up with registered RAM data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else begin
      s1_r <= issue;
    end
  end

  // product stage occupancy, mirrored from the MAC input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mac_busy_r <= 1'b0;
    end else begin
      mac_busy_r <= s1_r.valid;
    end
  end

  // RAM addressing: normal W[k][m], transpose W[m][k]; vector at m
  assign rd_row  = transpose_r ? m_r : k_r;
  assign rd_col  = transpose_r ? k_r : m_r;
  assign w_raddr = mvm_pkg::WADDR_W'(rd_row * mvm_pkg::MAX_COLS + rd_col);
  assign v_raddr = mvm_pkg::VADDR_W'(m_r);

  assign w_we    = in_accept && (in_command == mvm_pkg::CMD_MATRIX)
                   && (int'(in_row_index) < mvm_pkg::MAX_ROWS)
                   && (int'(in_col_index) < mvm_pkg::MAX_COLS);
  assign w_waddr = mvm_pkg::WADDR_W'(in_row_index * mvm_pkg::MAX_COLS + in_col_index);
  assign v_we    = in_accept && (in_command == mvm_pkg::CMD_VECTOR);
  assign v_waddr = mvm_pkg::VADDR_W'(in_vector_index);

  mvm_ram #(
    .DEPTH (mvm_pkg::WDEPTH),
    .WIDTH (mvm_pkg::VAL_W)
  ) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (in_matrix_value),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  mvm_ram #(
    .DEPTH (mvm_pkg::VEC_DEPTH),
    .WIDTH (mvm_pkg::VAL_W)
  ) u_vector_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (in_vector_value),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  mvm_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .term_in   (s1_r),
    .w_in      (signed'(w_rdata)),
    .v_in      (signed'(v_rdata)),
    .res_valid (out_valid),
    .res_index (out_result_index),
    .res_value (out_result_value),
    .res_last  (out_result_last)
  );

`include "matrix_vector_multiply_assert.svh"

  `MVM_ASSERT_NXT(a_start_sets_busy, run_start, busy)
  `MVM_ASSERT_IMP(a_pipe_only_when_busy, s1_r.valid, state_r != mvm_pkg::ST_IDLE)
  `MVM_ASSERT_NXT(a_last_ends_run, out_valid && out_result_last, !out_valid)

endmodule
